### sv/rlpf_pkg.sv
`timescale 1ns / 1ps
// rlpf_pkg: shared types and constants of the rgb led pulse fader
// no dependencies

package rlpf_pkg;

    localparam int LVL_W  = 8;
    localparam int FADE_W = 15;
    localparam int CYC_W  = 16;
    localparam int NUM_CH = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [LVL_W-1:0] t_level;
    // channel 0 red, 1 green, 2 blue
    typedef logic [NUM_CH-1:0][LVL_W-1:0] t_rgb;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_OFF   = 2'd0;
    localparam t_mode MODE_SOLID = 2'd1;
    localparam t_mode MODE_PULSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FADE  = 3'd5;

    localparam logic [CYC_W-1:0]  CYCLE_RST = 16'd1000;
    localparam logic [FADE_W-1:0] FADE_RST  = 15'd150;

    // scaler handshake toward the control
    typedef struct packed {
        logic              start;
        t_rgb              level;
        logic [FADE_W-1:0] num;
        logic [FADE_W-1:0] den;
    } t_scale_req;

    typedef struct packed {
        logic done;
        t_rgb quot;
    } t_scale_rsp;

endpackage

### sv/rlpf_scaler.sv
`timescale 1ns / 1ps
// rlpf_scaler: three lanes of floor(level * num / den), bit serial
// shift-add multiply over level bits, then restoring division; uses rlpf_pkg

module rlpf_scaler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlpf_pkg::t_scale_req i_req,
    output rlpf_pkg::t_scale_rsp o_rsp
);
    import rlpf_pkg::*;

    localparam int ACC_W = LVL_W + FADE_W;
    localparam int CNT_W = $clog2(2 * LVL_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [FADE_W-1:0]    r_num;
    logic [FADE_W-1:0]    r_den;
    logic [LVL_W-1:0]     r_lvl [NUM_CH];
    logic [ACC_W-1:0]     r_acc [NUM_CH];
    logic [ACC_W-1:0]     n_acc [NUM_CH];

    // first half multiplies, second half divides
    logic w_div_phase;
    assign w_div_phase = r_cnt[CNT_W-1];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            logic [FADE_W:0] t;
            logic [FADE_W:0] d;
            t = {r_acc[c][ACC_W-1:LVL_W], r_acc[c][LVL_W-1]};
            d = t - {1'b0, r_den};
            if (!w_div_phase) begin
                n_acc[c] = {r_acc[c][ACC_W-2:0], 1'b0}
                         + (r_lvl[c][LVL_W-1] ? ACC_W'(r_num) : '0);
            end else if (t >= {1'b0, r_den}) begin
                n_acc[c] = {d[FADE_W-1:0], r_acc[c][LVL_W-2:0], 1'b1};
            end else begin
                n_acc[c] = {t[FADE_W-1:0], r_acc[c][LVL_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(2 * LVL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            for (int c = 0; c < NUM_CH; c++) begin
                r_lvl[c] <= i_req.level[c];
                r_acc[c] <= '0;
            end
        end else if (r_busy) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_lvl[c] <= {r_lvl[c][LVL_W-2:0], 1'b0};
                r_acc[c] <= n_acc[c];
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        for (int c = 0; c < NUM_CH; c++) begin
            o_rsp.quot[c] = r_acc[c][LVL_W-1:0];
        end
    end

endmodule

### sv/rgb_led_pulse_fader.sv
`timescale 1ns / 1ps
// rgb_led_pulse_fader: off, solid or breathing drive of one rgb led
// uses rlpf_pkg and rlpf_scaler
//
// channels: s_axis carries one time step per transfer (tdata step_ms, tuser restart),
// m_axis returns one pixel per step (tdata red, green, blue, tuser rising_phase),
// the cfg channel writes the six registers by index (always ready).
// without scaling (off, solid, hold, zero fade) a step is registered as a
// result and then moved to the output register; while fading the bit-serial
// scaler runs first: 8 multiply steps and 8 divide steps shared by the three
// color lanes. one step is in work at a time: s_axis_tready rises again
// as soon as the result is moved to the output register, so a new step is
// taken while the previous pixel still waits on m_axis.
// a stalled receiver holds the output register; a finished result then waits
// in the block and no further step is taken until the register frees up.
// reset: mode off, levels 0, cycle 1000 ms, fade 150 ms, fade-in phase,
// elapsed time zero, no output pending.

module rgb_led_pulse_fader #(
    parameter int TIME_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // step_ms[7:0]
    input  logic [0:0]                        s_axis_tuser,  // restart[0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // red[7:0] green[15:8] blue[23:16]
    output logic [0:0]                        m_axis_tuser,  // rising_phase[0]
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rlpf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rlpf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rlpf_pkg::*;

    localparam int CW = (TIME_BITS > FADE_W) ? TIME_BITS : FADE_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCALE, ST_PEND} t_state;

    t_mode             r_mode;
    t_rgb              r_level;
    logic [CYC_W-1:0]  r_cycle;
    logic [FADE_W-1:0] r_fade;

    t_state                r_state,   n_state;
    logic                  r_fading,  n_fading;
    logic [TIME_BITS-1:0]  r_elapsed, n_elapsed;
    t_rgb                  r_res,     n_res;
    logic                  r_rising,  n_rising;
    logic                  r_out_valid, n_out_valid;
    t_rgb                  r_out,     n_out;
    logic                  r_out_rising, n_out_rising;

    t_scale_req w_req;
    t_scale_rsp w_rsp;
    t_scale_req w_req_start;
    logic       w_start;

    logic [FADE_W-1:0]    w_half;
    logic [FADE_W-1:0]    w_fade;
    logic [TIME_BITS:0]   w_sum;
    logic [TIME_BITS-1:0] w_enew;
    logic [CW-1:0]        w_eext;
    logic                 w_phase;
    logic                 w_in_fade;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OFF;
            r_level <= '0;
            r_cycle <= CYCLE_RST;
            r_fade  <= FADE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode     <= i_cfg_data[1:0];
                REG_RED:   r_level[0] <= i_cfg_data[LVL_W-1:0];
                REG_GREEN: r_level[1] <= i_cfg_data[LVL_W-1:0];
                REG_BLUE:  r_level[2] <= i_cfg_data[LVL_W-1:0];
                REG_CYCLE: r_cycle    <= i_cfg_data[CYC_W-1:0];
                REG_FADE:  r_fade     <= i_cfg_data[FADE_W-1:0];
                default: ;
            endcase
        end
    end

    // step arithmetic
    assign w_half    = r_cycle[CYC_W-1:1];
    assign w_fade    = (r_fade < w_half) ? r_fade : w_half;
    assign w_sum     = {1'b0, r_elapsed} + (TIME_BITS+1)'(s_axis_tdata);
    assign w_enew    = s_axis_tuser[0] ? '0 :
                       (w_sum[TIME_BITS] ? '1 : w_sum[TIME_BITS-1:0]);
    assign w_eext    = CW'(w_enew);
    assign w_phase   = s_axis_tuser[0] | r_fading;
    assign w_in_fade = w_eext < CW'(w_fade);

    always_comb begin
        w_req.start = 1'b0;
        w_req.level = r_level;
        w_req.den   = w_fade;
        w_req.num   = w_phase ? w_eext[FADE_W-1:0] : w_fade - w_eext[FADE_W-1:0];
    end

    always_comb begin
        w_req_start       = w_req;
        w_req_start.start = w_start;
    end

    rlpf_scaler u_scaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req_start),
        .o_rsp   (w_rsp)
    );

    // control
    always_comb begin
        n_state      = r_state;
        n_fading     = r_fading;
        n_elapsed    = r_elapsed;
        n_res        = r_res;
        n_rising     = r_rising;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_out_rising = r_out_rising;
        w_start      = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_rising  = 1'b1;
                    n_res     = '0;
                    n_fading  = 1'b1;
                    n_elapsed = '0;
                    n_state   = ST_PEND;
                    unique case (r_mode)
                        MODE_SOLID: begin
                            n_res = r_level;
                        end
                        MODE_PULSE: begin
                            n_rising  = w_phase;
                            n_fading  = w_phase;
                            n_elapsed = w_enew;
                            if (w_in_fade) begin
                                w_start = 1'b1;
                                n_state = ST_SCALE;
                            end else begin
                                if (w_phase) begin
                                    n_res = r_level;
                                end
                                if (w_eext >= CW'(w_half)) begin
                                    n_fading  = !w_phase;
                                    n_elapsed = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCALE: begin
                if (w_rsp.done) begin
                    n_res   = w_rsp.quot;
                    n_state = ST_PEND;
                end
            end
            ST_PEND: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out        = r_res;
                    n_out_rising = r_rising;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fading    <= 1'b1;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fading    <= n_fading;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
        end
        r_res        <= n_res;
        r_rising     <= n_rising;
        r_out        <= n_out;
        r_out_rising <= n_out_rising;
    end

    assign s_axis_tready   = (r_state == ST_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out;
    assign m_axis_tuser[0] = r_out_rising;

endmodule
